[src/whwc_pkg.sv]
package whwc_pkg;

    localparam int WINDOW_LEN_DEF   = 8;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int DIST_W      = 16;
    localparam int ANG_W       = 16;
    localparam int WRAP_W      = 18;
    localparam int Z_W         = 32;
    localparam int FRAC_SHIFT  = 24;
    localparam int ROUND_SHIFT = 16;
    localparam int ATAN_LEN    = 24;
    localparam int ATAN_IDX_W  = 5;
    localparam int SENSORS     = 4;
    localparam int SNAP_COUNT  = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_BASELINE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_LIMIT = 1'b1;

    localparam logic [DIST_W-1:0] BASELINE_RST = 16'd13107;
    localparam logic [DIST_W-1:0] LIMIT_RST    = 16'd655;

    localparam logic signed [WRAP_W-1:0] ANG_PI      = 18'sd25736;
    localparam logic signed [WRAP_W-1:0] ANG_HALF_PI = 18'sd12868;
    localparam logic signed [WRAP_W-1:0] ANG_TWO_PI  = 18'sd51472;
    localparam logic signed [Z_W-1:0]    ROUND_BIAS  = 32'sd32768;

    localparam logic signed [WRAP_W-1:0] SNAP_TARGETS [SNAP_COUNT] = '{
        -ANG_PI, -ANG_HALF_PI, 18'sd0, ANG_HALF_PI, ANG_PI
    };

    typedef struct packed {
        logic        [DIST_W-1:0] front_right_dist;
        logic        [DIST_W-1:0] back_right_dist;
        logic        [DIST_W-1:0] front_left_dist;
        logic        [DIST_W-1:0] back_left_dist;
        logic signed [ANG_W-1:0]  current_heading;
    } t_in_item;

    typedef struct packed {
        logic signed [ANG_W-1:0] new_heading;
        logic                    corrected;
        logic                    side_used;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DIST_W-1:0]    wdata;
    } t_cfg_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_LIM,
        S_VAR,
        S_CORDIC,
        S_DONE
    } t_state;

    function automatic logic signed [Z_W-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd421657428;
            5'd1:    v = 32'sd248918915;
            5'd2:    v = 32'sd131521918;
            5'd3:    v = 32'sd66762579;
            5'd4:    v = 32'sd33510843;
            5'd5:    v = 32'sd16771758;
            5'd6:    v = 32'sd8387925;
            5'd7:    v = 32'sd4194219;
            5'd8:    v = 32'sd2097141;
            5'd9:    v = 32'sd1048575;
            5'd10:   v = 32'sd524288;
            5'd11:   v = 32'sd262144;
            5'd12:   v = 32'sd131072;
            5'd13:   v = 32'sd65536;
            5'd14:   v = 32'sd32768;
            5'd15:   v = 32'sd16384;
            5'd16:   v = 32'sd8192;
            5'd17:   v = 32'sd4096;
            5'd18:   v = 32'sd2048;
            5'd19:   v = 32'sd1024;
            5'd20:   v = 32'sd512;
            5'd21:   v = 32'sd256;
            5'd22:   v = 32'sd128;
            5'd23:   v = 32'sd64;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [WRAP_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] a);
        logic signed [WRAP_W-1:0] r;
        if (a > ANG_PI) begin
            r = a - ANG_TWO_PI;
        end else if (a < -ANG_PI) begin
            r = a + ANG_TWO_PI;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

[src/whwc_if.sv]
interface whwc_in_if;
    whwc_pkg::t_in_item data;
    logic               valid;
    logic               ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface whwc_out_if;
    whwc_pkg::t_out_item data;
    logic                valid;
    logic                ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface whwc_cfg_if;
    whwc_pkg::t_cfg_item data;
    logic                valid;
    logic                ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/wall_heading_window_correct_core.sv]
// Heading correction from a steady side wall. Each input transaction carries four
// side IR distances and the present heading, and exactly one output transaction
// follows with the new heading. The last WINDOW_LEN samples of each sensor are kept in
// a small RAM with running sums and sums of squares. Once the window has been full and
// one more sample has arrived, the right pair and then the left pair are checked for a
// steady wall, and on success the heading is snapped to the nearest quarter turn plus
// atan2 of the mean distance difference over the baseline. The block takes one item at
// a time. Once the window is ready, an item makes nine passes through one shared multiplier,
// and a corrected item also makes CORDIC_STEPS passes through the iterative CORDIC unit.
// An item that leaves the window not yet ready skips the checks and goes to the output.
// Configuration writes are taken at any time but must only be issued while idle.
module wall_heading_window_correct_core #(
    parameter int WINDOW_LEN   = whwc_pkg::WINDOW_LEN_DEF,
    parameter int CORDIC_STEPS = whwc_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    whwc_in_if.sink           i_in,
    whwc_out_if.source        o_out,
    whwc_cfg_if.sink          i_cfg
);

    localparam int DW     = whwc_pkg::DIST_W;
    localparam int LOG_N  = $clog2(WINDOW_LEN);
    localparam int SUM_W  = DW + LOG_N;
    localparam int SQ_W   = 2 * DW + LOG_N;
    localparam int VW     = 2 * SUM_W;
    localparam int MW     = SUM_W + 2;
    localparam int AW     = LOG_N;
    localparam int FW     = $clog2(WINDOW_LEN + 2);
    localparam int NS     = whwc_pkg::SENSORS;
    localparam int WW     = whwc_pkg::WRAP_W;
    localparam int AGW    = whwc_pkg::ANG_W;

    whwc_pkg::t_state          r_state, n_state;
    logic [2:0]                r_cnt;
    whwc_pkg::t_in_item        r_in;
    logic [AW-1:0]             r_head;
    logic [FW-1:0]             r_fill;
    logic [SUM_W-1:0]          r_sum [NS];
    logic [SQ_W-1:0]           r_sq [NS];
    logic [VW-1:0]             r_limsq, r_prod;
    logic [2:0]                r_steady;
    logic signed [AGW-1:0]     r_base, r_hd;
    logic                      r_corr, r_side;
    whwc_pkg::t_out_item       r_out;
    logic                      r_out_valid;
    logic [DW-1:0]             r_cfg_base, r_cfg_dev;

    logic                      in_acc, out_free, full;
    logic [NS-1:0][DW-1:0]     in_d, old_d;
    logic [1:0]                k_upd, k_cmp;
    logic [DW-1:0]             nv, ov;
    logic [4*DW-1:0]           ram_rdata;
    logic                      ram_we, ram_re;
    logic signed [MW-1:0]      mul_a, mul_b;
    logic signed [2*MW-1:0]    product;
    logic [SUM_W-1:0]          lim, base_x;
    logic [VW-1:0]             nsq, spread;
    logic                      cmp_steady, pick_right, pick_left;
    logic signed [SUM_W:0]     diff;
    logic                      cordic_start, cordic_busy, cordic_done;
    logic signed [AGW-1:0]     cordic_angle;
    logic signed [WW-1:0]      snap_d, result;
    logic [WW-1:0]             snap_abs, snap_best;
    logic signed [AGW-1:0]     snap_base;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign full     = (r_fill >= FW'(WINDOW_LEN));

    assign i_in.ready  = (r_state == whwc_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign in_d  = {r_in.back_left_dist, r_in.front_left_dist,
                    r_in.back_right_dist, r_in.front_right_dist};
    assign old_d = ram_rdata;
    assign k_upd = r_cnt[1:0];
    assign k_cmp = 2'(r_cnt - 3'd1);
    assign nv    = in_d[k_upd];
    assign ov    = full ? old_d[k_upd] : '0;

    whwc_ram #(
        .WIDTH (4 * DW),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (in_d),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign lim     = SUM_W'(WINDOW_LEN) * SUM_W'(r_cfg_dev);
    assign base_x  = SUM_W'(WINDOW_LEN) * SUM_W'(r_cfg_base);
    assign product = mul_a * mul_b;

    assign nsq        = VW'(WINDOW_LEN) * VW'(r_sq[k_cmp]);
    assign spread     = nsq - r_prod;
    assign cmp_steady = (spread < r_limsq);
    assign pick_right = r_steady[0] && r_steady[1];
    assign pick_left  = r_steady[2] && cmp_steady;
    assign diff = pick_right ? ($signed({1'b0, r_sum[0]}) - $signed({1'b0, r_sum[1]}))
                             : ($signed({1'b0, r_sum[3]}) - $signed({1'b0, r_sum[2]}));

    whwc_cordic #(
        .DW    (SUM_W),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_y     (diff),
        .i_x     (base_x),
        .o_busy  (cordic_busy),
        .o_done  (cordic_done),
        .o_angle (cordic_angle)
    );

    always_comb begin
        snap_best = '1;
        snap_base = '0;
        snap_d    = '0;
        snap_abs  = '0;
        for (int t = 0; t < whwc_pkg::SNAP_COUNT; t++) begin
            snap_d   = whwc_pkg::wrap_angle(WW'(r_in.current_heading)
                                            - whwc_pkg::SNAP_TARGETS[t]);
            snap_abs = snap_d[WW-1] ? WW'(-snap_d) : WW'(snap_d);
            if (snap_abs < snap_best) begin
                snap_best = snap_abs;
                snap_base = AGW'(whwc_pkg::SNAP_TARGETS[t]);
            end
        end
    end

    assign result = whwc_pkg::wrap_angle(WW'(r_base) + WW'(cordic_angle));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            whwc_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = whwc_pkg::S_UPD;
                end
            end
            whwc_pkg::S_UPD: begin
                if (r_cnt == 3'd3) begin
                    n_state = full ? whwc_pkg::S_LIM : whwc_pkg::S_DONE;
                end
            end
            whwc_pkg::S_LIM: begin
                n_state = whwc_pkg::S_VAR;
            end
            whwc_pkg::S_VAR: begin
                if (r_cnt == 3'd4) begin
                    n_state = (pick_right || pick_left) ? whwc_pkg::S_CORDIC
                                                        : whwc_pkg::S_DONE;
                end
            end
            whwc_pkg::S_CORDIC: begin
                if (cordic_done) begin
                    n_state = whwc_pkg::S_DONE;
                end
            end
            whwc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = whwc_pkg::S_IDLE;
                end
            end
            default: n_state = whwc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        cordic_start = 1'b0;
        unique case (r_state)
            whwc_pkg::S_IDLE: begin
                ram_re = in_acc;
            end
            whwc_pkg::S_UPD: begin
                ram_we = (r_cnt == 3'd0);
                mul_a  = $signed(MW'(nv)) - $signed(MW'(ov));
                mul_b  = $signed(MW'(nv)) + $signed(MW'(ov));
            end
            whwc_pkg::S_LIM: begin
                mul_a = $signed(MW'(lim));
                mul_b = $signed(MW'(lim));
            end
            whwc_pkg::S_VAR: begin
                mul_a        = $signed(MW'(r_sum[k_upd]));
                mul_b        = $signed(MW'(r_sum[k_upd]));
                cordic_start = (r_cnt == 3'd4) && (pick_right || pick_left);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= whwc_pkg::S_IDLE;
            r_cnt       <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cfg_base  <= whwc_pkg::BASELINE_RST;
            r_cfg_dev   <= whwc_pkg::LIMIT_RST;
            for (int k = 0; k < NS; k++) begin
                r_sum[k] <= '0;
                r_sq[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    whwc_pkg::REG_SENSOR_BASELINE: r_cfg_base <= i_cfg.data.wdata;
                    whwc_pkg::REG_DEVIATION_LIMIT: r_cfg_dev  <= i_cfg.data.wdata;
                    default: begin
                    end
                endcase
            end
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else if (r_state == whwc_pkg::S_UPD || r_state == whwc_pkg::S_VAR) begin
                r_cnt <= r_cnt + 3'd1;
            end
            if (r_state == whwc_pkg::S_UPD) begin
                r_sum[k_upd] <= r_sum[k_upd] + SUM_W'(nv) - SUM_W'(ov);
                r_sq[k_upd]  <= r_sq[k_upd] + SQ_W'(product);
                if (r_cnt == 3'd3) begin
                    r_head <= (r_head == AW'(WINDOW_LEN - 1)) ? '0 : r_head + 1'b1;
                    if (r_fill <= FW'(WINDOW_LEN)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
            end
            if (r_state == whwc_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in   <= i_in.data;
            r_hd   <= i_in.data.current_heading;
            r_corr <= 1'b0;
            r_side <= 1'b0;
        end
        if (r_state == whwc_pkg::S_LIM) begin
            r_limsq <= VW'(product);
            r_base  <= snap_base;
        end
        if (r_state == whwc_pkg::S_VAR) begin
            if (r_cnt != 3'd4) begin
                r_prod <= VW'(product);
            end
            if (r_cnt != 3'd0 && r_cnt != 3'd4) begin
                r_steady[k_cmp] <= cmp_steady;
            end
            if (r_cnt == 3'd4) begin
                r_side <= !pick_right;
            end
        end
        if (r_state == whwc_pkg::S_CORDIC && cordic_done) begin
            r_hd   <= AGW'(result);
            r_corr <= 1'b1;
        end
        if (r_state == whwc_pkg::S_DONE && out_free) begin
            r_out.new_heading <= r_hd;
            r_out.corrected   <= r_corr;
            r_out.side_used   <= r_corr && r_side;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW_LEN + 1))
        else $error("window fill count beyond saturation");

    a_side_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.corrected) |-> !o_out.data.side_used)
        else $error("side reported without correction");

    a_corr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.corrected) |-> (r_fill == FW'(WINDOW_LEN + 1)))
        else $error("correction before window ready");

    a_cordic_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_busy |-> (r_state == whwc_pkg::S_CORDIC))
        else $error("CORDIC running outside its state");

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == whwc_pkg::S_UPD && r_cnt == 3'd0))
        else $error("accepted transaction did not start window update");

endmodule

[src/whwc_ram.sv]
module whwc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/whwc_cordic.sv]
module whwc_cordic #(
    parameter int DW    = 19,
    parameter int STEPS = whwc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [DW:0]                  i_y,
    input  logic        [DW-1:0]                i_x,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [whwc_pkg::ANG_W-1:0]   o_angle
);

    localparam int CW = DW + whwc_pkg::FRAC_SHIFT + 3;
    localparam int IW = $clog2(STEPS);

    logic signed [CW-1:0]              r_x, r_y, n_x, n_y;
    logic signed [whwc_pkg::Z_W-1:0]   r_z, n_z, zr;
    logic        [IW-1:0]              r_i;
    logic                              r_busy, r_done, r_zero;
    logic signed [CW-1:0]              xs, ys;
    logic signed [whwc_pkg::Z_W-1:0]   step_ang;

    always_comb begin
        xs       = r_x >>> r_i;
        ys       = r_y >>> r_i;
        step_ang = whwc_pkg::atan_q29(whwc_pkg::ATAN_IDX_W'(r_i));
        if (!r_y[CW-1]) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + step_ang;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - step_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= $signed(CW'(i_x)) <<< whwc_pkg::FRAC_SHIFT;
            r_y    <= CW'(i_y) <<< whwc_pkg::FRAC_SHIFT;
            r_z    <= '0;
            r_zero <= (i_y == '0);
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign zr      = r_z + whwc_pkg::ROUND_BIAS;
    assign o_angle = r_zero ? '0 : zr[whwc_pkg::Z_W-1:whwc_pkg::ROUND_SHIFT];
    assign o_busy  = r_busy;
    assign o_done  = r_done;

endmodule
